// ----- rtl/ard_squared_exponential_kernel_macros.svh -----
// Assertion macros shared by the kernel RTL
`ifndef ARD_SQUARED_EXPONENTIAL_KERNEL_MACROS_SVH
`define ARD_SQUARED_EXPONENTIAL_KERNEL_MACROS_SVH

// clocked check, off while reset is high
`define SEK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also covers reset cycles
`define SEK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sek_pkg.sv -----
// Constants for the squared-exponential ARD kernel pipeline
package sek_pkg;

  localparam int COORD_W = 16;
  localparam int REG_W   = 16;
  localparam int OUT_W   = 24;
  localparam int IDX_W   = 8;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_INV_SCALE0 = 8'd0;
  localparam logic [IDX_W-1:0] CFG_INV_SCALE1 = 8'd1;
  localparam logic [IDX_W-1:0] CFG_SIG_VAR    = 8'd2;
  localparam logic [IDX_W-1:0] CFG_NUGGET     = 8'd3;

  localparam logic [REG_W-1:0] INV_SCALE_RST = 16'd512;
  localparam logic [REG_W-1:0] SIG_VAR_RST   = 16'd256;
  localparam logic [REG_W-1:0] NUGGET_RST    = 16'd3;

  localparam logic [31:0] M_CLAMP   = 32'd8388608;   // 8.0 in Q.20
  localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [6:0]  SHIFT_MAX = 7'd47;
  localparam logic [OUT_W-1:0] OUT_MAX = 24'hFF_FFFF;

  localparam int TERMS = 12;          // Horner terms of exp(-r)

  // floor(2^32 / k) for k = 12 down to 1, indexed by Horner step
  localparam logic [32:0] RECIP [TERMS] = '{
    33'd357913941, 33'd390451572, 33'd429496729, 33'd477218588,
    33'd536870912, 33'd613566756, 33'd715827882, 33'd858993459,
    33'd1073741824, 33'd1431655765, 33'd2147483648, 33'd4294967296
  };

endpackage

// ----- rtl/ard_squared_exponential_kernel.sv -----
// Squared-exponential ARD covariance kernel, fully pipelined
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid / in_stall  | first_coord0/1, second_coord0/1, on_diagonal
//  out     | from block| out_valid / out_stall| cov_value
//  cfg     | to block  | cfg_write            | cfg_index, cfg_data
//
// One point pair per cycle unless out_stall holds the pipe; 7 front stages,
// 12 Horner steps of 3 stages each and 3 back stages.
// Rate is set by the Horner chain: one multiplier and one reciprocal divide
// per step, each behind its own register.
// The whole pipe moves as one: it advances unless a result sits in the
// output register while out_stall is high; in_stall mirrors that.
// rst clears valid bits and loads the configuration reset values.
`include "ard_squared_exponential_kernel_macros.svh"

module ard_squared_exponential_kernel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sek_pkg::COORD_W-1:0] first_coord0,
  input  logic signed [sek_pkg::COORD_W-1:0] first_coord1,
  input  logic signed [sek_pkg::COORD_W-1:0] second_coord0,
  input  logic signed [sek_pkg::COORD_W-1:0] second_coord1,
  input  logic                              on_diagonal,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sek_pkg::OUT_W-1:0]         cov_value,
  input  logic                              cfg_write,
  input  logic [sek_pkg::IDX_W-1:0]         cfg_index,
  input  logic [sek_pkg::REG_W-1:0]         cfg_data
);
  import sek_pkg::*;

  localparam int HSTG = 3 * TERMS;   // Horner stages

  // configuration
  logic [REG_W-1:0] inv_scale0, inv_scale1, sig_var, nugget;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale0 <= INV_SCALE_RST;
      inv_scale1 <= INV_SCALE_RST;
      sig_var    <= SIG_VAR_RST;
      nugget     <= NUGGET_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INV_SCALE0: inv_scale0 <= cfg_data;
        CFG_INV_SCALE1: inv_scale1 <= cfg_data;
        CFG_SIG_VAR:    sig_var    <= cfg_data;
        CFG_NUGGET:     nugget     <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: |difference|
  logic        v1, d1;
  logic [15:0] mag0, mag1;
  logic signed [16:0] diff0, diff1;
  assign diff0 = 17'(first_coord0) - 17'(second_coord0);
  assign diff1 = 17'(first_coord1) - 17'(second_coord1);

  // stage 2: scaled and clamped
  logic        v2, d2;
  logic [23:0] m0, m1;
  logic [31:0] mp0, mp1;
  assign mp0 = 32'(mag0) * 32'(inv_scale0);
  assign mp1 = 32'(mag1) * 32'(inv_scale1);

  // stage 3: squares, stage 4: sum
  logic        v3, d3, v4, d4;
  logic [47:0] sq0, sq1;
  logic [48:0] dsum;

  // stage 5: half sum and underflow flag
  logic        v5, d5, z5;
  logic [35:0] hq;
  logic [46:0] hsum;
  assign hsum = {1'b0, dsum[45:0]} + 47'd1024;

  // stage 6: times log2(e)
  logic        v6, d6, z6;
  logic [35:0] y6;
  logic [63:0] yprod;
  assign yprod = 64'(hq) * 64'(LOG2E_Q28);

  logic [59:0] rprod;
  assign rprod = 60'(y6[29:0]) * 60'(LN2_Q30);

  // side data that rides along the Horner chain; index 0 is stage 7
  logic        hv [HSTG+1];
  logic        hz [HSTG+1];
  logic        hd [HSTG+1];
  logic [5:0]  hn [HSTG+1];
  logic [29:0] hr [HSTG+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      for (int i = 0; i <= HSTG; i++) hv[i] <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      hv[0] <= v6;
      for (int i = 0; i < HSTG; i++) hv[i+1] <= hv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1   <= on_diagonal;
      mag0 <= diff0[16] ? 16'(-diff0) : diff0[15:0];
      mag1 <= diff1[16] ? 16'(-diff1) : diff1[15:0];
      d2   <= d1;
      m0   <= (mp0 > M_CLAMP) ? M_CLAMP[23:0] : mp0[23:0];
      m1   <= (mp1 > M_CLAMP) ? M_CLAMP[23:0] : mp1[23:0];
      d3   <= d2;
      sq0  <= 48'(m0) * 48'(m0);
      sq1  <= 48'(m1) * 48'(m1);
      d4   <= d3;
      dsum <= 49'(sq0) + 49'(sq1);
      d5   <= d4;
      z5   <= |dsum[48:46];
      hq   <= hsum[46:11];
      d6   <= d5;
      z6   <= z5;
      y6   <= yprod[63:28];
      hd[0] <= d6;
      hz[0] <= z6;
      hn[0] <= y6[35:30];
      hr[0] <= rprod[59:30];
      for (int i = 0; i < HSTG; i++) begin
        hd[i+1] <= hd[i];
        hz[i+1] <= hz[i];
        hn[i+1] <= hn[i];
        hr[i+1] <= hr[i];
      end
    end
  end

  // Horner chain for exp(-r): p = 1 - (r*p)/k, k = 12 down to 1
  logic [29:0] a_q  [TERMS];
  logic [29:0] b_q  [TERMS];
  logic [29:0] b_qe [TERMS];
  logic [30:0] c_p  [TERMS];
  logic [TERMS-1:0] rem_ok;

  for (genvar j = 0; j < TERMS; j++) begin : g_horner
    localparam logic [3:0] K = 4'(TERMS - j);
    logic [30:0] p_in;
    logic [60:0] pr;
    logic [62:0] qm;
    logic [29:0] qk, quo;
    logic [29:0] rem;

    if (j == 0) begin : g_first
      assign p_in = ONE_Q30;
    end else begin : g_next
      assign p_in = c_p[j-1];
    end

    // quotient estimate is taken from the same product that b_q captures
    assign pr  = 61'(hr[3*j]) * 61'(p_in);
    assign qm  = 63'(a_q[j]) * 63'(RECIP[j]);
    assign qk  = 30'(b_qe[j] * 30'(K));
    assign rem = b_q[j] - qk;
    assign quo = (rem >= 30'(K)) ? b_qe[j] + 30'd1 : b_qe[j];
    assign rem_ok[j] = !hv[3*j+2] || (rem < 30'(2 * K));

    always_ff @(posedge clk) begin
      if (adv) begin
        a_q[j]  <= pr[59:30];
        b_q[j]  <= a_q[j];
        b_qe[j] <= qm[61:32];
        c_p[j]  <= ONE_Q30 - 31'(quo);
      end
    end
  end

  // back end: amplitude, rounded shift, nugget and saturation
  logic        t_v, t_z, t_d, u_v, u_d;
  logic [46:0] t_prod;
  logic [6:0]  t_s;
  logic [25:0] u_term;
  logic [47:0] rnd, sumr, shr;
  logic [26:0] res;

  assign rnd  = 48'd1 << (t_s - 7'd1);
  assign sumr = {1'b0, t_prod} + rnd;
  assign shr  = sumr >> t_s;
  assign res  = 27'(u_term) + (u_d ? 27'({nugget, 8'd0}) : 27'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v       <= 1'b0;
      u_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      t_v       <= hv[HSTG];
      u_v       <= t_v;
      out_valid <= u_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_z    <= hz[HSTG];
      t_d    <= hd[HSTG];
      t_prod <= 47'(sig_var) * 47'(c_p[TERMS-1]);
      t_s    <= 7'd22 + 7'(hn[HSTG]);
      u_d    <= t_d;
      u_term <= (t_z || t_s > SHIFT_MAX) ? 26'd0 : shr[25:0];
      cov_value <= (res > 27'(OUT_MAX)) ? OUT_MAX : res[OUT_W-1:0];
    end
  end

  `SEK_ASSERT_RST(a_reset_clears, rst |=> !out_valid && !v1 && !t_v, "valid bits not cleared by reset")
  `SEK_ASSERT(a_div_correct, &rem_ok, "reciprocal divide off by more than one")
  `SEK_ASSERT(a_exp_bound, hv[HSTG] |-> c_p[TERMS-1] <= ONE_Q30, "exp term above one")
  `SEK_ASSERT(a_far_zero, t_v && t_z && adv |=> u_term == 26'd0, "far pair gave nonzero term")

endmodule
